FILE: sv/fvts_pkg.sv
// Shared types, constants and the portal table for the fid/vid transition sequencer.
package fvts_pkg;

  // Field widths
  localparam int FID_W  = 6;
  localparam int VID_W  = 6;
  localparam int STEP_W = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_ADDR_W-1:0] CFG_FINE_STEP = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_STEPS = 1'b1;
  localparam logic [STEP_W-1:0]     MAX_STEPS_RESET = 4'd8;

  // Item codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_STATUS = 1'b1;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Fid limits and the portal region boundary
  localparam logic [FID_W-1:0] PORTAL_EDGE    = 6'h18;
  localparam logic [FID_W:0]   FID_CAP        = 7'((25 - 4) * 2);
  localparam logic [FID_W-1:0] FALLBACK_LIMIT = 6'((10 - 4) * 2);
  localparam logic [FID_W:0]   BOTTOM_OFFSET  = 7'(5 * 2);

  // Portal table: 13 x 13, row = goal/2, column = current/2
  localparam int PORTAL_DIM = 13;
  localparam int PORTAL_DEPTH = PORTAL_DIM * PORTAL_DIM;
  localparam logic [4:0] MISS = 5'h1f;
  localparam logic [4:0] PORTAL_ROM [PORTAL_DEPTH] = '{
    5'd0,  MISS,  MISS,  MISS,  5'd0,  5'd0,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    MISS,  5'd0,  MISS,  MISS,  MISS,  5'd5,  5'd5,  5'd5,  5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    MISS,  MISS,  5'd0,  MISS,  MISS,  MISS,  MISS,  5'd6,  5'd6,  5'd6,  5'd13, 5'd14, 5'd15,
    MISS,  MISS,  MISS,  5'd0,  MISS,  MISS,  MISS,  MISS,  MISS,  5'd7,  5'd7,  5'd7,  5'd15,
    5'd8,  MISS,  MISS,  MISS,  5'd0,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd9,  5'd9,  MISS,  MISS,  5'd9,  5'd0,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd9,  5'd10, MISS,  MISS,  5'd9,  5'd10, 5'd0,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd9,  5'd11, 5'd11, MISS,  5'd9,  5'd10, 5'd11, 5'd0,  5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd9,  5'd11, 5'd12, MISS,  5'd9,  5'd10, 5'd11, 5'd12, 5'd0,  5'd12, 5'd13, 5'd14, 5'd15,
    5'd9,  5'd11, 5'd13, 5'd13, 5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd0,  5'd13, 5'd14, 5'd15,
    5'd9,  5'd11, 5'd13, 5'd14, 5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd0,  5'd14, 5'd15,
    5'd9,  5'd11, 5'd13, 5'd15, 5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd0,  5'd15,
    5'd9,  5'd11, 5'd13, 5'd15, 5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd0
  };

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MAXVID,
    PH_STEP,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic             action;
    logic [FID_W-1:0] req_fid;
    logic [VID_W-1:0] req_vid;
    logic [FID_W-1:0] now_fid;
    logic [VID_W-1:0] now_vid;
    logic [FID_W-1:0] top_fid;
    logic [FID_W-1:0] bottom_fid;
    logic [VID_W-1:0] top_vid;
    logic             pending;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [FID_W-1:0] out_fid;
    logic [VID_W-1:0] out_vid;
    logic             long_wait;
    logic             fid_failed;
    logic             vid_failed;
  } result_t;

  typedef struct packed {
    logic              fine_step_enable;
    logic [STEP_W-1:0] max_steps;
  } cfg_t;

  // Portal lookup; both halves are below 12 when used, so the index stays in range
  function automatic logic [4:0] portal_lookup(logic [3:0] goal_half, logic [3:0] cur_half);
    logic [7:0] idx;
    idx = 8'(goal_half) * 8'(PORTAL_DIM) + 8'(cur_half);
    if (idx < 8'(PORTAL_DEPTH)) begin
      return PORTAL_ROM[idx];
    end
    return MISS;
  endfunction

endpackage

FILE: sv/fid_vid_transition_sequencer.sv
// Top level: stream ports, configuration registers, input and result registers.
//
// One beat is accepted per clock while the output is not stalled. A beat lands in the
// input register and is decided by the sequencer core in the next cycle when the output is free,
// at the same edge that loads the result register and raises out_tvalid. The rate of
// one beat per cycle, while not stalled, is set by the core's state update. The input side
// keeps accepting while a result waits on a stalled output, up to the one beat the input
// register holds. Start beats (tuser = 0) always give a result and restart the sequence, or end
// it at once when now matches req; status beats (tuser = 1) with pending set, or while idle, give no result.
module fid_vid_transition_sequencer
  import fvts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [5:0] req_fid, [11:6] req_vid, [17:12] now_fid, [23:18] now_vid,
  // [29:24] top_fid, [35:30] bottom_fid, [41:36] top_vid, [42] pending, [47:43] zero
  input  logic [47:0]           in_tdata,
  // [0] action
  input  logic                  in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [5:0] out_fid, [11:6] out_vid, [12] long_wait, [13] fid_failed,
  // [14] vid_failed, [15] zero
  output logic [15:0]           out_tdata,
  // [0] kind
  output logic                  out_tuser,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    in_v_r;
  result_t res_r;
  logic    out_v_r;
  logic    proc;
  logic    res_valid;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_step_enable <= 1'b0;
      cfg_r.max_steps        <= MAX_STEPS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FINE_STEP: cfg_r.fine_step_enable <= cfg_wdata[0];
        CFG_MAX_STEPS: cfg_r.max_steps        <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the held beat is decided when the result slot is free or draining
  assign proc      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.action     <= in_tuser;
      item_r.req_fid    <= in_tdata[5:0];
      item_r.req_vid    <= in_tdata[11:6];
      item_r.now_fid    <= in_tdata[17:12];
      item_r.now_vid    <= in_tdata[23:18];
      item_r.top_fid    <= in_tdata[29:24];
      item_r.bottom_fid <= in_tdata[35:30];
      item_r.top_vid    <= in_tdata[41:36];
      item_r.pending    <= in_tdata[42];
    end
  end

  fvts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .item      (item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= res_valid;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {1'b0, res_r.vid_failed, res_r.fid_failed, res_r.long_wait,
                       res_r.out_vid, res_r.out_fid};

  // A held beat that is not decided stays held
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !proc |=> in_v_r)
    else $error("input beat dropped without being decided");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |-> !proc)
    else $error("result register overwritten while stalled");

endmodule

FILE: sv/fvts_core.sv
// Sequencer state and the combinational next-step decision for each beat.
module fvts_core
  import fvts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    proc,       // item in the input register is processed this cycle
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  phase_t            phase_r, phase_nxt;
  logic [FID_W-1:0]  fid_now_r, fid_now_nxt;
  logic [VID_W-1:0]  vid_now_r, vid_now_nxt;
  logic [FID_W-1:0]  fid_goal_r, fid_goal_nxt;
  logic [VID_W-1:0]  vid_goal_r, vid_goal_nxt;
  logic [FID_W-1:0]  fid_limit_r, fid_limit_nxt;
  logic [STEP_W-1:0] steps_left_r, steps_left_nxt;

  // Stepping decision inputs
  logic [FID_W-1:0]  cur;
  logic [VID_W-1:0]  vid_cur;
  logic              up;
  logic [FID_W-2:0]  half_diff;
  logic [4:0]        portal_t;
  logic [FID_W:0]    step_fid;   // one bit wider so a step past 63 fails the limit check
  logic              step_ok;
  logic [FID_W:0]    bottom_lim;
  logic [FID_W-1:0]  lim;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      fid_now_r    <= '0;
      vid_now_r    <= '0;
      fid_goal_r   <= '0;
      vid_goal_r   <= '0;
      fid_limit_r  <= '0;
      steps_left_r <= '0;
    end else if (proc) begin
      phase_r      <= phase_nxt;
      fid_now_r    <= fid_now_nxt;
      vid_now_r    <= vid_now_nxt;
      fid_goal_r   <= fid_goal_nxt;
      vid_goal_r   <= vid_goal_nxt;
      fid_limit_r  <= fid_limit_nxt;
      steps_left_r <= steps_left_nxt;
    end
  end

  // Current pair as seen by the step decision
  always_comb begin
    cur     = (phase_r == PH_STEP) ? item.now_fid : fid_now_r;
    vid_cur = (phase_r == PH_MAXVID) ? item.now_vid : vid_now_r;
  end

  // Next fid: 200 MHz step, portal table, or 100 MHz step
  always_comb begin
    up        = cur < fid_goal_r;
    half_diff = up ? (fid_goal_r[FID_W-1:1] - cur[FID_W-1:1])
                   : (cur[FID_W-1:1] - fid_goal_r[FID_W-1:1]);
    portal_t  = portal_lookup(fid_goal_r[4:1], cur[4:1]);
    step_fid  = '0;
    step_ok   = 1'b1;
    if (cur == fid_goal_r || steps_left_r == '0) begin
      step_ok = 1'b0;
    end else if (half_diff == 5'd1 || fid_goal_r >= PORTAL_EDGE || cur >= PORTAL_EDGE) begin
      step_fid = up ? {1'b0, cur} + 7'd2 : {1'b0, cur} - 7'd2;
    end else if (half_diff > 5'd1) begin
      if (portal_t == MISS) begin
        step_ok = 1'b0;
      end else if (portal_t == 5'd0) begin
        step_fid = {1'b0, fid_goal_r};
      end else begin
        step_fid = {1'b0, portal_t - 5'd4, 1'b0};
      end
    end else if (cfg.fine_step_enable) begin
      step_fid = {1'b0, cur} + 7'd1;
    end else begin
      step_ok = 1'b0;
    end
    if (step_ok && step_fid > {1'b0, fid_limit_r}) begin
      step_ok = 1'b0;
    end
  end

  // Fid limit clamp for a start beat
  always_comb begin
    bottom_lim = {1'b0, item.bottom_fid} + BOTTOM_OFFSET;
    if ({1'b0, item.top_fid} < FID_CAP) begin
      lim = item.top_fid;
    end else if (bottom_lim < FID_CAP) begin
      lim = bottom_lim[FID_W-1:0];
    end else begin
      lim = FALLBACK_LIMIT;
    end
  end

  // Next state and result
  always_comb begin
    phase_nxt      = phase_r;
    fid_now_nxt    = fid_now_r;
    vid_now_nxt    = vid_now_r;
    fid_goal_nxt   = fid_goal_r;
    vid_goal_nxt   = vid_goal_r;
    fid_limit_nxt  = fid_limit_r;
    steps_left_nxt = steps_left_r;
    res_valid      = 1'b0;
    res            = '0;

    if (item.action == ACT_START) begin
      res_valid = 1'b1;
      if (item.now_fid == item.req_fid && item.now_vid == item.req_vid) begin
        phase_nxt   = PH_IDLE;
        res.kind    = KIND_DONE;
        res.out_fid = item.req_fid;
        res.out_vid = item.req_vid;
      end else begin
        fid_limit_nxt  = lim;
        fid_goal_nxt   = item.req_fid;
        vid_goal_nxt   = item.req_vid;
        fid_now_nxt    = item.now_fid;
        vid_now_nxt    = item.now_vid;
        steps_left_nxt = cfg.max_steps;
        phase_nxt      = PH_MAXVID;
        res.kind       = KIND_WRITE;
        res.out_fid    = item.now_fid;
        res.out_vid    = item.top_vid;
      end
    end else if (phase_r != PH_IDLE && !item.pending) begin
      res_valid = 1'b1;
      case (phase_r)
        PH_MAXVID, PH_STEP: begin
          fid_now_nxt = cur;
          vid_now_nxt = vid_cur;
          if (cur != fid_goal_r && steps_left_r != '0) begin
            steps_left_nxt = steps_left_r - 4'd1;
          end
          res.kind = KIND_WRITE;
          if (step_ok) begin
            phase_nxt     = PH_STEP;
            res.out_fid   = step_fid[FID_W-1:0];
            res.out_vid   = vid_cur;
            res.long_wait = 1'b1;
          end else begin
            phase_nxt   = PH_FINAL;
            res.out_fid = cur;
            res.out_vid = vid_goal_r;
          end
        end
        PH_FINAL: begin
          vid_now_nxt    = item.now_vid;
          phase_nxt      = PH_IDLE;
          res.kind       = KIND_DONE;
          res.out_fid    = fid_now_r;
          res.out_vid    = item.now_vid;
          res.fid_failed = fid_now_r != fid_goal_r;
          res.vid_failed = item.now_vid != vid_goal_r;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // A control write never carries fail flags
  a_write_no_fail: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_WRITE |-> !res.fid_failed && !res.vid_failed)
    else $error("fail flag set on a control write");

  // A long wait only goes with a fid step
  a_long_wait_step: assert property (@(posedge clk) disable iff (!rst_n)
    proc && res_valid && res.long_wait |-> phase_nxt == PH_STEP)
    else $error("long wait without a fid step");

  // Status beats while idle make no result
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE && item.action == ACT_STATUS |-> !res_valid)
    else $error("result from a status beat while idle");

  // The step budget never grows during a sequence
  a_budget_down: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item.action == ACT_STATUS |=> steps_left_r <= $past(steps_left_r))
    else $error("step budget grew on a status beat");

endmodule
